// ===== rtl/msdp_pkg.sv =====
// ----------------------------------------------------------------------------
// msdp_pkg
// Shared types, constants and helpers of the masked seam finder.
// ----------------------------------------------------------------------------
package msdp_pkg;

    // default sizes
    localparam int DEF_MAX_COLUMNS = 1024;
    localparam int DEF_MAX_ROWS    = 64;
    localparam int DEF_COST_WIDTH  = 32;

    // stream field widths
    localparam int ENERGY_W    = 8;
    localparam int SEAM_COL_W  = 10;
    localparam int SEAM_ROW_W  = 6;
    localparam int OUT_DATA_W  = SEAM_COL_W + SEAM_ROW_W;

    // configuration registers
    localparam int CFG_COLS_W   = 11;
    localparam int CFG_ROWS_W   = 7;
    localparam int MASK_COST_W  = 24;
    localparam int CFG_DATA_W   = 24;
    localparam int CFG_INDEX_W  = 2;

    localparam logic [CFG_INDEX_W-1:0] CFG_COLUMNS_IN_USE = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ROWS_IN_USE    = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_MASKED_COST    = 2'd2;

    localparam logic [CFG_COLS_W-1:0]  CFG_COLS_RESET   = 11'd1024;
    localparam logic [CFG_ROWS_W-1:0]  CFG_ROWS_RESET   = 7'd64;
    localparam logic [MASK_COST_W-1:0] CFG_MASKED_RESET = 24'hFFFFFF;

    // upper neighbour taken by a cell
    typedef enum logic [1:0] {
        CH_CENTRE = 2'd0,
        CH_LEFT   = 2'd1,
        CH_RIGHT  = 2'd2
    } choice_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD_FIRST,
        ST_RD_NEXT,
        ST_CALC,
        ST_WRITE,
        ST_EMIT,
        ST_BT_STEP
    } ctrl_state_t;

    typedef struct packed {
        logic capture;
        logic rd_first;
        logic rd_next;
        logic load_c;
        logic calc;
        logic write;
        logic seam_read;
        logic seam_step;
    } dp_cmd_t;

    typedef struct packed {
        logic px_top;
        logic px_first;
        logic px_last;
        logic cur_top;
        logic cur_first;
        logic cur_last;
        logic cur_bottom;
        logic seam_top;
    } dp_status_t;

    // index width for a given depth, at least one bit
    function automatic int idx_w(input int depth);
        return (depth > 1) ? $clog2(depth) : 1;
    endfunction

endpackage

// ===== rtl/msdp_ctrl.sv =====
// ----------------------------------------------------------------------------
// msdp_ctrl
// Sequencer for pixel update, cost memory reads and seam backtrack.
// ----------------------------------------------------------------------------
module msdp_ctrl
    import msdp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    output logic       m_tvalid,
    input  logic       m_tready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        m_tvalid   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.capture = 1'b1;
                    priority if (status.px_top)
                    begin
                        state_next = ST_WRITE;
                    end
                    else if (status.px_first)
                    begin
                        state_next = ST_RD_FIRST;
                    end
                    else if (status.px_last)
                    begin
                        state_next = ST_CALC;
                    end
                    else
                    begin
                        state_next = ST_RD_NEXT;
                    end
                end
            end
            ST_RD_FIRST:
            begin
                cmd.rd_first = 1'b1;
                state_next   = ST_RD_NEXT;
            end
            ST_RD_NEXT:
            begin
                cmd.rd_next = 1'b1;
                cmd.load_c  = status.cur_first;
                state_next  = ST_CALC;
            end
            ST_CALC:
            begin
                cmd.calc   = 1'b1;
                state_next = ST_WRITE;
            end
            ST_WRITE:
            begin
                cmd.write = 1'b1;
                if (status.cur_last && status.cur_bottom)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_EMIT:
            begin
                m_tvalid = 1'b1;
                if (m_tready)
                begin
                    if (status.seam_top)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        cmd.seam_read = 1'b1;
                        state_next    = ST_BT_STEP;
                    end
                end
            end
            ST_BT_STEP:
            begin
                cmd.seam_step = 1'b1;
                state_next    = ST_EMIT;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && m_tvalid))
        else $error("input and output side active together");

    a_emit_entry: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> ($past(state_reg) == ST_WRITE) || ($past(state_reg) == ST_BT_STEP))
        else $error("seam transaction offered from wrong state");

endmodule

// ===== rtl/msdp_dp.sv =====
// ----------------------------------------------------------------------------
// msdp_dp
// Cost line memory, neighbour window, path choice memory and seam backtrack.
// ----------------------------------------------------------------------------
module msdp_dp
    import msdp_pkg::*;
#(
    parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
    parameter int MAX_ROWS    = DEF_MAX_ROWS,
    parameter int COST_WIDTH  = DEF_COST_WIDTH
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  dp_cmd_t                            cmd,
    output dp_status_t                         status,
    input  logic [idx_w(MAX_COLUMNS)-1:0]      cols_last,
    input  logic [idx_w(MAX_ROWS)-1:0]         rows_last,
    input  logic [MASK_COST_W-1:0]             masked_cost,
    input  logic [ENERGY_W-1:0]                energy,
    input  logic                               masked,
    output logic [SEAM_COL_W-1:0]              seam_column,
    output logic [SEAM_ROW_W-1:0]              seam_row,
    output logic                               seam_last
);

    localparam int COL_W      = idx_w(MAX_COLUMNS);
    localparam int ROW_W      = idx_w(MAX_ROWS);
    localparam int PATH_DEPTH = MAX_ROWS * MAX_COLUMNS;
    localparam int PATH_AW    = idx_w(PATH_DEPTH);
    localparam int EXT_W      = (COST_WIDTH > MASK_COST_W) ? COST_WIDTH : MASK_COST_W;

    localparam logic [COST_WIDTH-1:0] COST_MAX = {COST_WIDTH{1'b1}};
    localparam logic [COL_W-1:0]      COL_END  = COL_W'(MAX_COLUMNS - 1);

    logic [COST_WIDTH-1:0] cost_mem [MAX_COLUMNS];
    choice_t               path_mem [PATH_DEPTH];

    // position counters and captured pixel
    logic [COL_W-1:0]      pc_reg, pc_next;
    logic [ROW_W-1:0]      pr_reg, pr_next;
    logic [COL_W-1:0]      cur_col_reg;
    logic [ROW_W-1:0]      cur_row_reg;
    logic [COST_WIDTH-1:0] cost_reg;
    logic                  cur_top_reg, cur_first_reg, cur_last_reg, cur_bottom_reg;

    // window and result
    logic [COST_WIDTH-1:0] win_l_reg, win_c_reg, rdata_reg, pick_reg;
    choice_t               choice_reg, path_rdata_reg;
    logic [COST_WIDTH-1:0] best_cost_reg, best_cost_next;
    logic [COL_W-1:0]      best_col_reg, best_col_next;
    logic [COL_W-1:0]      seam_col_reg, seam_col_next;
    logic [ROW_W-1:0]      seam_row_reg;

    logic [COL_W-1:0]      px_col;
    logic [ROW_W-1:0]      px_row;
    logic [EXT_W-1:0]      mc_ext;
    logic [COST_WIDTH-1:0] masked_sat, cost_in;
    logic [COST_WIDTH-1:0] pick_val;
    choice_t               choice_val;
    logic [COST_WIDTH:0]   sum_wide;
    logic [COST_WIDTH-1:0] sum_val;
    logic                  best_take;
    logic                  cost_rd_en;
    logic [COL_W-1:0]      cost_rd_addr;
    logic [PATH_AW-1:0]    path_wr_addr, path_rd_addr;

    // pixel position and cost
    always_comb
    begin
        px_col = (pc_reg < cols_last) ? pc_reg : cols_last;
        px_row = (pr_reg < rows_last) ? pr_reg : rows_last;
        mc_ext = EXT_W'(masked_cost);
        if (mc_ext > EXT_W'(COST_MAX))
        begin
            masked_sat = COST_MAX;
        end
        else
        begin
            masked_sat = COST_WIDTH'(mc_ext);
        end
        cost_in = masked ? masked_sat : COST_WIDTH'(energy);
    end

    // neighbour choice
    always_comb
    begin
        if (cur_first_reg)
        begin
            if (rdata_reg < win_c_reg)
            begin
                pick_val   = rdata_reg;
                choice_val = CH_RIGHT;
            end
            else
            begin
                pick_val   = win_c_reg;
                choice_val = CH_CENTRE;
            end
        end
        else if (cur_last_reg)
        begin
            if (win_l_reg < win_c_reg)
            begin
                pick_val   = win_l_reg;
                choice_val = CH_LEFT;
            end
            else
            begin
                pick_val   = win_c_reg;
                choice_val = CH_CENTRE;
            end
        end
        else if ((win_l_reg <= win_c_reg) && (win_l_reg <= rdata_reg))
        begin
            pick_val   = win_l_reg;
            choice_val = CH_LEFT;
        end
        else if (rdata_reg <= win_c_reg)
        begin
            pick_val   = rdata_reg;
            choice_val = CH_RIGHT;
        end
        else
        begin
            pick_val   = win_c_reg;
            choice_val = CH_CENTRE;
        end
    end

    // saturating sum and bottom row minimum
    always_comb
    begin
        sum_wide = {1'b0, cost_reg} + {1'b0, pick_reg};
        if (cur_top_reg)
        begin
            sum_val = cost_reg;
        end
        else if (sum_wide[COST_WIDTH])
        begin
            sum_val = COST_MAX;
        end
        else
        begin
            sum_val = sum_wide[COST_WIDTH-1:0];
        end
        best_take      = cur_bottom_reg && ((cur_col_reg == '0) || (sum_val < best_cost_reg));
        best_cost_next = best_take ? sum_val : best_cost_reg;
        best_col_next  = best_take ? cur_col_reg : best_col_reg;
    end

    // counter advance
    always_comb
    begin
        pc_next = pc_reg;
        pr_next = pr_reg;
        if (cmd.write)
        begin
            if (cur_last_reg)
            begin
                pc_next = '0;
                pr_next = cur_bottom_reg ? '0 : cur_row_reg + 1'b1;
            end
            else
            begin
                pc_next = cur_col_reg + 1'b1;
                pr_next = cur_row_reg;
            end
        end
    end

    // backtrack step
    always_comb
    begin
        seam_col_next = seam_col_reg;
        unique case (path_rdata_reg)
            CH_LEFT:
            begin
                if (seam_col_reg != '0)
                begin
                    seam_col_next = seam_col_reg - 1'b1;
                end
            end
            CH_RIGHT:
            begin
                if (seam_col_reg != COL_END)
                begin
                    seam_col_next = seam_col_reg + 1'b1;
                end
            end
            default:
            begin
                seam_col_next = seam_col_reg;
            end
        endcase
    end

    // memory addressing
    always_comb
    begin
        cost_rd_en   = cmd.rd_first || cmd.rd_next;
        cost_rd_addr = cmd.rd_first ? '0 : cur_col_reg + 1'b1;
        path_wr_addr = PATH_AW'(cur_row_reg) * PATH_AW'(MAX_COLUMNS) + PATH_AW'(cur_col_reg);
        path_rd_addr = PATH_AW'(seam_row_reg) * PATH_AW'(MAX_COLUMNS) + PATH_AW'(seam_col_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg         <= '0;
            pr_reg         <= '0;
            cur_top_reg    <= 1'b0;
            cur_first_reg  <= 1'b0;
            cur_last_reg   <= 1'b0;
            cur_bottom_reg <= 1'b0;
            best_cost_reg  <= '0;
            best_col_reg   <= '0;
        end
        else
        begin
            pc_reg <= pc_next;
            pr_reg <= pr_next;
            if (cmd.capture)
            begin
                cur_top_reg    <= (px_row == '0);
                cur_first_reg  <= (px_col == '0);
                cur_last_reg   <= (px_col == cols_last);
                cur_bottom_reg <= (px_row == rows_last);
            end
            if (cmd.write)
            begin
                best_cost_reg <= best_cost_next;
                best_col_reg  <= best_col_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            cur_col_reg <= px_col;
            cur_row_reg <= px_row;
            cost_reg    <= cost_in;
        end
        if (cmd.load_c)
        begin
            win_c_reg <= rdata_reg;
        end
        if (cmd.calc)
        begin
            pick_reg   <= pick_val;
            choice_reg <= choice_val;
            win_l_reg  <= win_c_reg;
            win_c_reg  <= rdata_reg;
        end
        if (cmd.write && cur_last_reg && cur_bottom_reg)
        begin
            seam_col_reg <= best_col_next;
            seam_row_reg <= cur_row_reg;
        end
        else if (cmd.seam_step)
        begin
            seam_col_reg <= seam_col_next;
            seam_row_reg <= seam_row_reg - 1'b1;
        end
    end

    // previous row costs, overwritten in place once the window has moved past
    always_ff @(posedge clk)
    begin
        if (cmd.write)
        begin
            cost_mem[cur_col_reg] <= sum_val;
        end
        if (cost_rd_en)
        begin
            rdata_reg <= cost_mem[cost_rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.write && !cur_top_reg)
        begin
            path_mem[path_wr_addr] <= choice_reg;
        end
        if (cmd.seam_read)
        begin
            path_rdata_reg <= path_mem[path_rd_addr];
        end
    end

    always_comb
    begin
        status.px_top     = (px_row == '0);
        status.px_first   = (px_col == '0);
        status.px_last    = (px_col == cols_last);
        status.cur_top    = cur_top_reg;
        status.cur_first  = cur_first_reg;
        status.cur_last   = cur_last_reg;
        status.cur_bottom = cur_bottom_reg;
        status.seam_top   = (seam_row_reg == '0);
    end

    assign seam_column = SEAM_COL_W'(seam_col_reg);
    assign seam_row    = SEAM_ROW_W'(seam_row_reg);
    assign seam_last   = (seam_row_reg == '0);

    a_pick_bound: assert property (@(posedge clk) disable iff (!rst_n)
        $past(cmd.calc) |-> (pick_reg <= $past(win_c_reg)))
        else $error("chosen neighbour cost above centre cost");

    a_step_not_top: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.seam_step |-> (seam_row_reg != '0))
        else $error("backtrack stepped past top row");

    a_row_down: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.seam_step |=> (seam_row_reg == $past(seam_row_reg) - 1'b1))
        else $error("seam row did not move up by one");

    a_col_move: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.seam_step |=> (seam_col_reg == $past(seam_col_reg))
                       || (seam_col_reg == $past(seam_col_reg) + 1'b1)
                       || (seam_col_reg == $past(seam_col_reg) - 1'b1))
        else $error("seam column moved by more than one");

endmodule

// ===== rtl/masked_seam_dp_finder_top.sv =====
// ----------------------------------------------------------------------------
// masked_seam_dp_finder_top
// Vertical seam search over masked pixel energies, seam emitted bottom-up.
// ----------------------------------------------------------------------------
// Pixels enter in raster order, one transaction each. A top row pixel is
// captured and written; an inner pixel adds a cost read and neighbour choice,
// the first pixel of a lower row two cost reads and the choice, and the last
// pixel of a lower row the choice only, as set by the single port cost line
// memory, read through a three-entry sliding window, and by the controller
// handling one pixel at a time. After the last pixel the seam leaves bottom
// row first, one transaction per row, with a path memory read after each
// accepted entry but the top row one; no pixel is taken until it is accepted.
// ----------------------------------------------------------------------------
module masked_seam_dp_finder_top
    import msdp_pkg::*;
#(
    parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
    parameter int MAX_ROWS    = DEF_MAX_ROWS,
    parameter int COST_WIDTH  = DEF_COST_WIDTH
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [ENERGY_W-1:0]    s_tdata,    // energy
    input  logic                   s_tuser,    // masked
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_DATA_W-1:0]  m_tdata,    // seam_column, seam_row
    output logic                   m_tlast,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

    localparam int COL_W  = idx_w(MAX_COLUMNS);
    localparam int ROW_W  = idx_w(MAX_ROWS);
    localparam int CCMP_W = (COL_W + 1 > CFG_COLS_W) ? COL_W + 1 : CFG_COLS_W;
    localparam int RCMP_W = (ROW_W + 1 > CFG_ROWS_W) ? ROW_W + 1 : CFG_ROWS_W;

    logic [CFG_COLS_W-1:0]  cfg_cols_reg;
    logic [CFG_ROWS_W-1:0]  cfg_rows_reg;
    logic [MASK_COST_W-1:0] cfg_masked_reg;

    logic [CCMP_W-1:0]      cols_eff;
    logic [RCMP_W-1:0]      rows_eff;
    logic [COL_W-1:0]       cols_last;
    logic [ROW_W-1:0]       rows_last;

    dp_cmd_t                cmd;
    dp_status_t             status;
    logic [SEAM_COL_W-1:0]  seam_column;
    logic [SEAM_ROW_W-1:0]  seam_row;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_cols_reg   <= CFG_COLS_RESET;
            cfg_rows_reg   <= CFG_ROWS_RESET;
            cfg_masked_reg <= CFG_MASKED_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_COLUMNS_IN_USE: cfg_cols_reg   <= cfg_wdata[CFG_COLS_W-1:0];
                CFG_ROWS_IN_USE:    cfg_rows_reg   <= cfg_wdata[CFG_ROWS_W-1:0];
                CFG_MASKED_COST:    cfg_masked_reg <= cfg_wdata[MASK_COST_W-1:0];
                default:            cfg_cols_reg   <= cfg_cols_reg;
            endcase
        end
    end

    // saturate width and height to the supported range
    always_comb
    begin
        if (cfg_cols_reg < CFG_COLS_W'(2))
        begin
            cols_eff = CCMP_W'(2);
        end
        else if (CCMP_W'(cfg_cols_reg) > CCMP_W'(MAX_COLUMNS))
        begin
            cols_eff = CCMP_W'(MAX_COLUMNS);
        end
        else
        begin
            cols_eff = CCMP_W'(cfg_cols_reg);
        end
        if (cfg_rows_reg < CFG_ROWS_W'(1))
        begin
            rows_eff = RCMP_W'(1);
        end
        else if (RCMP_W'(cfg_rows_reg) > RCMP_W'(MAX_ROWS))
        begin
            rows_eff = RCMP_W'(MAX_ROWS);
        end
        else
        begin
            rows_eff = RCMP_W'(cfg_rows_reg);
        end
        cols_last = COL_W'(cols_eff - 1'b1);
        rows_last = ROW_W'(rows_eff - 1'b1);
    end

    msdp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    msdp_dp #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_ROWS    (MAX_ROWS),
        .COST_WIDTH  (COST_WIDTH)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .cols_last   (cols_last),
        .rows_last   (rows_last),
        .masked_cost (cfg_masked_reg),
        .energy      (s_tdata),
        .masked      (s_tuser),
        .seam_column (seam_column),
        .seam_row    (seam_row),
        .seam_last   (m_tlast)
    );

    assign m_tdata = {seam_row, seam_column};

endmodule

// ===== tb/seam_checker.sv =====
// ----------------------------------------------------------------------------
// seam_checker
// Watches the pixel, seam and register ports of the masked seam finder, runs
// its own cumulative-cost search over every accepted pixel and compares each
// seam transaction, in order, against the columns that search traces back.
// ----------------------------------------------------------------------------
module seam_checker
    import msdp_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    input  logic                   s_tready,
    input  logic [ENERGY_W-1:0]    s_tdata,    // energy
    input  logic                   s_tuser,    // masked
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic [OUT_DATA_W-1:0]  m_tdata,    // seam_column, seam_row
    input  logic                   m_tlast,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    output int                     errors,
    output int                     pending,
    output int                     checked
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CW = DEF_COST_WIDTH;

    typedef struct packed {
        logic [SEAM_COL_W-1:0] column;
        logic [SEAM_ROW_W-1:0] row_idx;
        logic                  top_row;
    } seam_entry_t;

    logic [CFG_COLS_W-1:0]  width_reg;
    logic [CFG_ROWS_W-1:0]  height_reg;
    logic [MASK_COST_W-1:0] mask_cost_reg;
    logic [CW-1:0]          above_cost [DEF_MAX_COLUMNS];
    logic [CW-1:0]          row_cost   [DEF_MAX_COLUMNS];
    choice_t                route      [DEF_MAX_ROWS][DEF_MAX_COLUMNS];
    int unsigned            at_col;
    int unsigned            at_row;
    int unsigned            low_col;
    logic [CW-1:0]          low_cost;
    seam_entry_t            seam_due [$];
    seam_entry_t            got;
    seam_entry_t            want;
    int                     fail_count;
    int                     hits;

    assign errors  = fail_count;
    assign checked = hits;

    task automatic report_mismatch(input string what);
        $display("%0t ns seam transaction %0d: %s", $time, hits, what);
        fail_count++;
    endtask

    function automatic void absorb_pixel(input logic [ENERGY_W-1:0] energy,
                                         input logic masked);
        int unsigned cols;
        int unsigned rows;
        int unsigned col;
        int unsigned row;
        int unsigned trace_col;
        logic [CW:0] own;
        logic [CW:0] pick;
        logic [CW:0] c;
        logic [CW:0] l;
        logic [CW:0] r;
        logic [CW:0] total;
        choice_t     ch;
        seam_entry_t entry;

        cols = (width_reg < 2) ? 2 : (width_reg > DEF_MAX_COLUMNS) ? DEF_MAX_COLUMNS
                                                                    : width_reg;
        rows = (height_reg < 1) ? 1 : (height_reg > DEF_MAX_ROWS) ? DEF_MAX_ROWS
                                                                  : height_reg;
        col  = (at_col < cols - 1) ? at_col : cols - 1;
        row  = (at_row < rows - 1) ? at_row : rows - 1;
        own  = masked ? (CW+1)'(mask_cost_reg) : (CW+1)'(energy);

        if (row == 0)
            total = own;
        else
        begin
            c    = {1'b0, above_cost[col]};
            pick = c;
            ch   = CH_CENTRE;
            if (col == 0)
            begin
                r = {1'b0, above_cost[1]};
                if (r < c)
                begin
                    pick = r;
                    ch   = CH_RIGHT;
                end
            end
            else if (col == cols - 1)
            begin
                l = {1'b0, above_cost[col-1]};
                if (l < c)
                begin
                    pick = l;
                    ch   = CH_LEFT;
                end
            end
            else
            begin
                l = {1'b0, above_cost[col-1]};
                r = {1'b0, above_cost[col+1]};
                if (l < pick)
                    pick = l;
                if (r < pick)
                    pick = r;
                // ties go left, then right, then straight up
                if (pick == l)
                    ch = CH_LEFT;
                else if (pick == r)
                    ch = CH_RIGHT;
                else
                    ch = CH_CENTRE;
            end
            route[row][col] = ch;
            total = own + pick;
        end
        if (total[CW])
            total = {1'b0, {CW{1'b1}}};
        row_cost[col] = total[CW-1:0];

        if (row == rows - 1 && (col == 0 || total[CW-1:0] < low_cost))
        begin
            low_cost = total[CW-1:0];
            low_col  = col;
        end

        if (col == cols - 1)
        begin
            above_cost = row_cost;
            at_col     = 0;
            if (row == rows - 1)
            begin
                // walk the stored choices from the bottom row back to the top
                trace_col = low_col;
                for (int k = rows - 1; k >= 0; k--)
                begin
                    entry.column  = trace_col[SEAM_COL_W-1:0];
                    entry.row_idx = k[SEAM_ROW_W-1:0];
                    entry.top_row = (k == 0);
                    seam_due = {seam_due, entry};
                    if (k > 0)
                    begin
                        ch = route[k][trace_col];
                        if (ch == CH_LEFT && trace_col > 0)
                            trace_col--;
                        else if (ch == CH_RIGHT && trace_col + 1 < DEF_MAX_COLUMNS)
                            trace_col++;
                    end
                end
                at_row = 0;
            end
            else
                at_row = row + 1;
        end
        else
        begin
            at_col = col + 1;
            at_row = row;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg     = CFG_COLS_RESET;
            height_reg    = CFG_ROWS_RESET;
            mask_cost_reg = CFG_MASKED_RESET;
            at_col        = 0;
            at_row        = 0;
            low_col       = 0;
            low_cost      = '0;
            foreach (above_cost[i])
            begin
                above_cost[i] = '0;
                row_cost[i]   = '0;
            end
            foreach (route[i, j])
                route[i][j] = CH_CENTRE;
            seam_due.delete();
            pending <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got.column  = m_tdata[SEAM_COL_W-1:0];
                got.row_idx = m_tdata[OUT_DATA_W-1:SEAM_COL_W];
                got.top_row = m_tlast;
                if (seam_due.size() == 0)
                    report_mismatch($sformatf("unexpected column %0d row %0d last %0b",
                                              got.column, got.row_idx, got.top_row));
                else
                begin
                    want = seam_due.pop_front();
                    if (got !== want)
                        report_mismatch($sformatf(
                            "column %0d row %0d last %0b, wanted %0d %0d %0b",
                            got.column, got.row_idx, got.top_row,
                            want.column, want.row_idx, want.top_row));
                end
                hits++;
            end

            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_COLUMNS_IN_USE: width_reg     = cfg_wdata[CFG_COLS_W-1:0];
                    CFG_ROWS_IN_USE:    height_reg    = cfg_wdata[CFG_ROWS_W-1:0];
                    CFG_MASKED_COST:    mask_cost_reg = cfg_wdata[MASK_COST_W-1:0];
                    default: ;
                endcase
            end

            if (s_tvalid && s_tready)
                absorb_pixel(s_tdata, s_tuser);

            pending <= seam_due.size();
        end
    end

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Stimulus for the masked seam finder: bands of pixels, each under its own
// register setting, with random gaps on the pixel side and random stalls on
// the seam side. A checker alongside the block predicts and compares.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import msdp_pkg::*;

    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_INDEX = 2'd3;

    typedef logic [ENERGY_W:0] pixel_q_t [$];

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [ENERGY_W-1:0]    s_tdata;
    logic                   s_tuser;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_DATA_W-1:0]  m_tdata;
    logic                   m_tlast;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_wdata;

    int          errors;
    int          pending;
    int          checked;
    int          pixels_sent;
    int          bands_run;
    int          random_px;
    bit          src_calm;
    bit          sink_calm;
    int unsigned sink_hold;
    int unsigned sink_tick;

    masked_seam_dp_finder_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    seam_checker i_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .errors    (errors),
        .pending   (pending),
        .checked   (checked)
    );

    always #1 clk = ~clk;

    function automatic int unsigned idle_length();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 60)
            return 0;
        if (pick < 90)
            return $urandom_range(1, 3);
        if (pick < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic pixel_q_t random_pixels(input int unsigned n,
                                               input int unsigned mask_pct,
                                               input int unsigned energy_hi);
        pixel_q_t          q;
        logic              masked;
        logic [ENERGY_W:0] px;
        for (int unsigned i = 0; i < n; i++)
        begin
            masked = ($urandom_range(0, 99) < mask_pct);
            px     = {masked, ENERGY_W'($urandom_range(0, energy_hi))};
            q      = {q, px};
        end
        return q;
    endfunction

    // seam side: short stalls mostly, a few long ones, calm stretches between
    always @(posedge clk)
    begin
        sink_tick <= sink_tick + 1;
        if (sink_tick % 200 == 0)
            sink_calm <= ($urandom_range(0, 3) == 0);
        if (!rst_n)
            m_tready <= 1'b0;
        else if (sink_hold > 0)
        begin
            m_tready  <= 1'b0;
            sink_hold <= sink_hold - 1;
        end
        else
        begin
            m_tready <= 1'b1;
            if (!sink_calm)
                sink_hold <= idle_length();
        end
    end

    task automatic send_pixel(input logic [ENERGY_W:0] px);
        int unsigned gap;
        gap = src_calm ? 0 : idle_length();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= px[ENERGY_W-1:0];
        s_tuser  <= px[ENERGY_W];
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pixels_sent++;
    endtask

    // program the band while idle, stream it, then hold off until the seam is in
    task automatic play_band(input logic [CFG_DATA_W-1:0] w_word,
                             input logic [CFG_DATA_W-1:0] h_word,
                             input logic [CFG_DATA_W-1:0] mc,
                             input pixel_q_t pixels);
        src_calm = ($urandom_range(0, 3) == 0);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_COLUMNS_IN_USE;
        cfg_wdata <= w_word;
        @(posedge clk);
        cfg_index <= CFG_ROWS_IN_USE;
        cfg_wdata <= h_word;
        @(posedge clk);
        cfg_index <= CFG_MASKED_COST;
        cfg_wdata <= mc;
        @(posedge clk);
        cfg_we <= 1'b0;
        foreach (pixels[i])
            send_pixel(pixels[i]);
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        bands_run++;
    endtask

    initial
    begin
        pixel_q_t              band_px;
        int unsigned           w;
        int unsigned           h;
        int unsigned           ew;
        int unsigned           eh;
        int unsigned           pick;
        int unsigned           mask_pct;
        logic [CFG_DATA_W-1:0] w_word;
        logic [CFG_DATA_W-1:0] h_word;
        logic [CFG_DATA_W-1:0] mc;

        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = CFG_COLUMNS_IN_USE;
        cfg_wdata = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // three by three: ties in every column, masked pixels, energy extremes
        band_px = {9'h005, 9'h005, 9'h005,
                   9'h1FF, 9'h0FF, 9'h000,
                   9'h007, 9'h100, 9'h007};
        play_band(24'd3, 24'd3, CFG_MASKED_RESET, band_px);

        // unused index, then width and height that wrap to zero: single-row band
        cfg_we    <= 1'b1;
        cfg_index <= CFG_SPARE_INDEX;
        cfg_wdata <= CFG_DATA_W'($urandom);
        @(posedge clk);
        band_px = {9'h109, 9'h000};
        play_band(24'hFFF800, 24'hFFFF80, 24'h000000, band_px);

        // two columns, both edge rules, masked cost inside the energy range
        band_px = {9'h004, 9'h004, 9'h101, 9'h002,
                   9'h003, 9'h003, 9'h0FF, 9'h000};
        play_band(24'hABC802, 24'h000004, 24'h000003, band_px);

        // deepest band, height clamped
        play_band(24'd2, 24'd127, 24'd0, random_pixels(128, 30, 3));

        while (random_px < 110)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 6)
                w = $urandom_range(0, 1);
            else if (pick < 80)
                w = $urandom_range(2, 9);
            else
                w = $urandom_range(10, 32);
            pick = $urandom_range(0, 99);
            if (pick < 5)
                h = 0;
            else if (pick < 10)
                h = $urandom_range(65, 127);
            else if (pick < 15)
                h = 64;
            else if (pick < 80)
                h = $urandom_range(1, 6);
            else
                h = $urandom_range(7, 16);
            if (h > 16)
                w = $urandom_range(0, 3);
            ew = (w < 2) ? 2 : w;
            eh = (h < 1) ? 1 : (h > 64) ? 64 : h;
            if (random_px + ew * eh > 130)
                continue;

            w_word = CFG_DATA_W'(w);
            h_word = CFG_DATA_W'(h);
            if ($urandom_range(0, 4) == 0)
            begin
                w_word[CFG_DATA_W-1:CFG_COLS_W] = (CFG_DATA_W-CFG_COLS_W)'($urandom);
                h_word[CFG_DATA_W-1:CFG_ROWS_W] = (CFG_DATA_W-CFG_ROWS_W)'($urandom);
            end

            case ($urandom_range(0, 3))
                0:       mc = '0;
                1:       mc = CFG_MASKED_RESET;
                2:       mc = CFG_DATA_W'($urandom_range(0, 300));
                default: mc = CFG_DATA_W'($urandom);
            endcase
            case ($urandom_range(0, 3))
                0:       mask_pct = 0;
                1:       mask_pct = 10;
                2:       mask_pct = 35;
                default: mask_pct = 90;
            endcase

            band_px = random_pixels(ew * eh, mask_pct,
                                    ($urandom_range(0, 2) == 0) ? 3 : 255);
            play_band(w_word, h_word, mc, band_px);
            random_px += ew * eh;
        end

        repeat (20) @(posedge clk);
        $display("%0d pixels in %0d bands streamed, %0d seam transactions compared",
                 pixels_sent, bands_run, checked);
        $display("widths 2 to 32 with wrapped low values, 1 to 64 rows with clamped heights");
        if (errors == 0 && pending == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        #1_600_000;
        $display("run timed out with %0d seam transactions outstanding", pending);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/msdp_pkg.sv
rtl/msdp_ctrl.sv
rtl/msdp_dp.sv
rtl/masked_seam_dp_finder_top.sv
tb/seam_checker.sv
tb/tb.sv
